// ===== rtl/core/qte_pkg.sv =====
// Shared constants, types and the arctangent table for the quaternion to Euler core.
`default_nettype none

package qte_pkg;

    // operand width into the arctangent pipes
    localparam int OP_W         = 35;
    // Q13 angle width out of the arctangent pipes
    localparam int ANG_W        = 17;
    localparam int IN_W         = 16;
    localparam int PROD_W       = 32;
    localparam int CMP_W        = 58;

    localparam int CORDIC_STEPS = 16;
    localparam int NORM_BITS    = 41;
    localparam int NRM_W        = NORM_BITS + 1;
    localparam int XY_W         = 45;
    localparam int ACC_W        = 20;

    localparam int DIV_STEPS    = 31;
    localparam int DIV_W        = 33;
    localparam int Q_W          = 31;
    localparam int R_W          = 32;
    localparam int SQ_W         = 62;
    localparam int SQRT_STEPS   = 31;

    localparam int FRONT_LAT    = 3;
    localparam int RATIO_LAT    = DIV_STEPS + 2 + SQRT_STEPS;
    localparam int ATAN_LAT     = 5 + CORDIC_STEPS + 1;
    localparam int PIPE_LAT     = FRONT_LAT + RATIO_LAT + ATAN_LAT;

    localparam int PI_Q13       = 25736;
    localparam int HALF_PI_Q16  = 102944;

    typedef enum logic [1:0] {
        CASE_REGULAR = 2'd0,
        CASE_POS     = 2'd1,
        CASE_NEG     = 2'd2
    } sing_case_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] z;
        logic signed [ANG_W-1:0] y;
    } early_ang_t;

    // atan(2^-i) in Q16
    function automatic logic signed [ACC_W-1:0] atan_q16(input int unsigned idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:       v = ACC_W'(51472);
            1:       v = ACC_W'(30385);
            2:       v = ACC_W'(16055);
            3:       v = ACC_W'(8150);
            4:       v = ACC_W'(4091);
            5:       v = ACC_W'(2047);
            6:       v = ACC_W'(1024);
            7:       v = ACC_W'(512);
            8:       v = ACC_W'(256);
            9:       v = ACC_W'(128);
            10:      v = ACC_W'(64);
            11:      v = ACC_W'(32);
            12:      v = ACC_W'(16);
            13:      v = ACC_W'(8);
            14:      v = ACC_W'(4);
            15:      v = ACC_W'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qte_atan2.sv =====
// Pipelined atan2: magnitude normalize, half-plane fold, 16 vectoring CORDIC stages, Q13 round.
`default_nettype none

module qte_atan2 (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [qte_pkg::OP_W-1:0]   in_y,
    input  wire logic signed [qte_pkg::OP_W-1:0]   in_x,
    output logic signed [qte_pkg::ANG_W-1:0]       angle
);

    localparam int NB    = qte_pkg::NORM_BITS;
    localparam int NW    = qte_pkg::NRM_W;
    localparam int XW    = qte_pkg::XY_W;
    localparam int AW    = qte_pkg::ACC_W;
    localparam int STEPS = qte_pkg::CORDIC_STEPS;

    // abs stage
    logic [qte_pkg::OP_W:0] abs_x, abs_y;
    logic [NB-1:0]          m_in;

    logic [NB-1:0]          nm_reg [0:3];
    logic signed [NW-1:0]   nx_reg [0:3];
    logic signed [NW-1:0]   ny_reg [0:3];
    logic                   nz_reg [0:3];

    logic signed [XW-1:0]   cx_reg [0:STEPS];
    logic signed [XW-1:0]   cy_reg [0:STEPS];
    logic signed [AW-1:0]   ca_reg [0:STEPS];
    logic                   cz_reg [0:STEPS];

    logic signed [qte_pkg::ANG_W-1:0] angle_reg;

    always_comb begin
        abs_x = in_x[qte_pkg::OP_W-1] ? -((qte_pkg::OP_W+1)'(in_x)) : (qte_pkg::OP_W+1)'(in_x);
        abs_y = in_y[qte_pkg::OP_W-1] ? -((qte_pkg::OP_W+1)'(in_y)) : (qte_pkg::OP_W+1)'(in_y);
        m_in  = NB'(abs_x | abs_y);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nm_reg[0] <= m_in;
            nx_reg[0] <= NW'(in_x);
            ny_reg[0] <= NW'(in_y);
            nz_reg[0] <= (m_in == '0);
        end
    end

    // each stage tries two left shifts, largest first, keeping the OR of magnitudes below 2^41
    for (genvar j = 0; j < 3; j++) begin : g_norm
        localparam int SH_A = 32 >> (2 * j);
        localparam int SH_B = SH_A / 2;
        logic [NB-1:0]        tm;
        logic signed [NW-1:0] tx, ty;

        always_comb begin
            tm = nm_reg[j];
            tx = nx_reg[j];
            ty = ny_reg[j];
            if (tm[NB-1 -: SH_A] == '0) begin
                tm = tm << SH_A;
                tx = tx <<< SH_A;
                ty = ty <<< SH_A;
            end
            if (tm[NB-1 -: SH_B] == '0) begin
                tm = tm << SH_B;
                tx = tx <<< SH_B;
                ty = ty <<< SH_B;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nm_reg[j+1] <= tm;
                nx_reg[j+1] <= tx;
                ny_reg[j+1] <= ty;
                nz_reg[j+1] <= nz_reg[j];
            end
        end
    end

    // fold left half plane into the right one
    logic signed [XW-1:0] rx, ry, fx, fy;
    logic signed [AW-1:0] fa;

    always_comb begin
        rx = XW'(nx_reg[3]);
        ry = XW'(ny_reg[3]);
        fx = rx;
        fy = ry;
        fa = '0;
        if (rx < 0) begin
            if (ry >= 0) begin
                fx = ry;
                fy = -rx;
                fa = AW'(qte_pkg::HALF_PI_Q16);
            end else begin
                fx = -ry;
                fy = rx;
                fa = -AW'(qte_pkg::HALF_PI_Q16);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[0] <= fx;
            cy_reg[0] <= fy;
            ca_reg[0] <= fa;
            cz_reg[0] <= nz_reg[3];
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_cordic
        logic signed [XW-1:0] dx, dy;

        always_comb begin
            dx = cy_reg[i] >>> i;
            dy = cx_reg[i] >>> i;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (cy_reg[i] > 0) begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    ca_reg[i+1] <= ca_reg[i] + qte_pkg::atan_q16(i);
                end else begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    ca_reg[i+1] <= ca_reg[i] - qte_pkg::atan_q16(i);
                end
                cz_reg[i+1] <= cz_reg[i];
            end
        end
    end

    logic signed [AW-1:0] rnd;

    always_comb begin
        rnd = ca_reg[STEPS] + AW'(4);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= cz_reg[STEPS] ? '0 : qte_pkg::ANG_W'(rnd >>> 3);
        end
    end

    assign angle = angle_reg;

endmodule

`default_nettype wire

// ===== rtl/core/qte_ratio.sv =====
// Pipelined asin operands: ratio 2*abcd/unit by restoring division, then cosine leg by bit-serial square root.
`default_nettype none

module qte_ratio (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic [qte_pkg::DIV_W-1:0]         num_mag,
    input  wire logic [qte_pkg::DIV_W-1:0]         unit,
    input  wire logic                              num_neg,
    input  wire logic                              unit_zero,
    output logic signed [qte_pkg::R_W-1:0]         ratio,
    output logic [qte_pkg::Q_W-1:0]                cosine
);

    localparam int DS = qte_pkg::DIV_STEPS;
    localparam int DW = qte_pkg::DIV_W;
    localparam int QW = qte_pkg::Q_W;
    localparam int RW = qte_pkg::R_W;
    localparam int SW = qte_pkg::SQ_W;
    localparam int SS = qte_pkg::SQRT_STEPS;

    // divider: one quotient bit per stage
    logic [DW:0]   src_rem [0:DS-1];
    logic [DW-1:0] src_d   [0:DS-1];
    logic [QW-1:0] src_q   [0:DS-1];
    logic          src_n   [0:DS-1];
    logic          src_z   [0:DS-1];

    logic [DW:0]   drem_reg [0:DS-1];
    logic [DW-1:0] dd_reg   [0:DS-1];
    logic [QW-1:0] dq_reg   [0:DS-1];
    logic          dn_reg   [0:DS-1];
    logic          dz_reg   [0:DS-1];

    for (genvar k = 0; k < DS; k++) begin : g_div
        logic          ge;
        logic [DW:0]   nr;

        if (k == 0) begin : g_first
            assign src_rem[k] = {1'b0, num_mag};
            assign src_d[k]   = unit;
            assign src_q[k]   = '0;
            assign src_n[k]   = num_neg;
            assign src_z[k]   = unit_zero;
        end else begin : g_rest
            assign src_rem[k] = drem_reg[k-1];
            assign src_d[k]   = dd_reg[k-1];
            assign src_q[k]   = dq_reg[k-1];
            assign src_n[k]   = dn_reg[k-1];
            assign src_z[k]   = dz_reg[k-1];
        end

        always_comb begin
            ge = (src_rem[k] >= {1'b0, src_d[k]});
            nr = ge ? (src_rem[k] - {1'b0, src_d[k]}) : src_rem[k];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                drem_reg[k] <= {nr[DW-1:0], 1'b0};
                dd_reg[k]   <= src_d[k];
                dq_reg[k]   <= {src_q[k][QW-2:0], ge};
                dn_reg[k]   <= src_n[k];
                dz_reg[k]   <= src_z[k];
            end
        end
    end

    // clamp and sign
    logic [QW-1:0]        qc;
    logic [QW-1:0]        qc_reg;
    logic signed [RW-1:0] rc_reg;

    always_comb begin
        qc = dq_reg[DS-1];
        if (dz_reg[DS-1]) begin
            qc = '0;
        end else if (qc > (QW'(1) << (QW-1))) begin
            qc = QW'(1) << (QW-1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qc_reg <= qc;
            rc_reg <= dn_reg[DS-1] ? -RW'(qc) : RW'(qc);
        end
    end

    logic [SW-1:0]        sq_reg;
    logic signed [RW-1:0] rs_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= SW'(qc_reg) * SW'(qc_reg);
            rs_reg <= rc_reg;
        end
    end

    // square root of 2^60 - r*r, one root bit per stage
    logic [SW-1:0]        src_v  [0:SS-1];
    logic [SW-1:0]        src_r  [0:SS-1];
    logic signed [RW-1:0] src_rr [0:SS-1];

    logic [SW-1:0]        sv_reg [0:SS-1];
    logic [SW-1:0]        sr_reg [0:SS-1];
    logic signed [RW-1:0] rr_reg [0:SS-1];

    for (genvar k = 0; k < SS; k++) begin : g_sqrt
        localparam int BPOS = 2 * (SS - 1 - k);
        logic [SW-1:0] bit_w, trial;

        if (k == 0) begin : g_first
            assign src_v[k]  = (SW'(1) << (2 * (SS - 1))) - sq_reg;
            assign src_r[k]  = '0;
            assign src_rr[k] = rs_reg;
        end else begin : g_rest
            assign src_v[k]  = sv_reg[k-1];
            assign src_r[k]  = sr_reg[k-1];
            assign src_rr[k] = rr_reg[k-1];
        end

        always_comb begin
            bit_w = SW'(1) << BPOS;
            trial = src_r[k] + bit_w;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (src_v[k] >= trial) begin
                    sv_reg[k] <= src_v[k] - trial;
                    sr_reg[k] <= (src_r[k] >> 1) + bit_w;
                end else begin
                    sv_reg[k] <= src_v[k];
                    sr_reg[k] <= src_r[k] >> 1;
                end
                rr_reg[k] <= src_rr[k];
            end
        end
    end

    assign ratio  = rr_reg[SS-1];
    assign cosine = sr_reg[SS-1][QW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/quaternion_to_euler_core.sv =====
// Top level: quaternion in, Euler angles and singularity flag out, fully pipelined.
//
// Input stream s_*: one quaternion per request, tdata = {z, y, x, w}, 16-bit signed Q1.14 each.
// Output stream m_*: tdata = {pad, angle_about_y, angle_about_x, angle_about_z} in radians
// with 13 fraction bits; tuser carries the singularity flag (0 regular, 1 positive, 2 negative).
// The request passes 90 register stages, the first one loading at the accepting edge: 3 front stages
// (products, sums, singularity compare), 64 stages for the ratio divider, clamp, squaring and square
// root, 22 atan2 stages (normalize, fold, CORDIC, round), and the output register.
// Throughput is one quaternion per cycle while the pipeline is not stalled; every stage holds its own valid bit.
// The z and y angles run early and wait in a delay line until the x angle catches up.
// When the output holds a result the receiver has not taken, the pipeline keeps moving
// as long as its last stage is empty; only a full last stage stalls it, and then s_tready
// drops. Nothing is dropped or repeated across a stall.
// Reset (aresetn low, synchronous) clears all valid bits and the output valid; data
// registers are not reset. The block has no state between requests.
`default_nettype none

module quaternion_to_euler_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // angle_about_z[16:0], angle_about_x[32:17],
                                        // angle_about_y[48:33], zero pad[55:49]
    output logic [1:0]       m_tuser    // singular_case[1:0]
);

    localparam int IW = qte_pkg::IN_W;
    localparam int PW = qte_pkg::PROD_W;
    localparam int OW = qte_pkg::OP_W;
    localparam int CW = qte_pkg::CMP_W;
    localparam int AW = qte_pkg::ANG_W;
    localparam int PL = qte_pkg::PIPE_LAT;
    localparam int RL = qte_pkg::RATIO_LAT;
    localparam int CL = qte_pkg::RATIO_LAT + qte_pkg::ATAN_LAT;

    logic pipe_en;
    logic vld_reg [0:PL-1];

    // stage 1: products
    logic signed [IW-1:0] qw, qx, qy, qz;
    logic signed [PW-1:0] w2_reg, x2_reg, y2_reg, z2_reg;
    logic signed [PW-1:0] wx_reg, yz_reg, wz_reg, xy_reg, wy_reg, xz_reg;
    logic signed [IW-1:0] w1_reg, y1_reg;

    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            w2_reg <= qw * qw;
            x2_reg <= qx * qx;
            y2_reg <= qy * qy;
            z2_reg <= qz * qz;
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            wy_reg <= qw * qy;
            xz_reg <= qx * qz;
            w1_reg <= qw;
            y1_reg <= qy;
        end
    end

    // stage 2: sums
    logic signed [OW-1:0] unit_reg, abcd_reg, adbc_reg, acbd_reg, zx_reg, yx_reg;
    logic signed [IW-1:0] w2p_reg, y2p_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            unit_reg <= OW'(w2_reg) + OW'(x2_reg) + OW'(y2_reg) + OW'(z2_reg);
            abcd_reg <= OW'(wx_reg) + OW'(yz_reg);
            adbc_reg <= OW'(wz_reg) - OW'(xy_reg);
            acbd_reg <= OW'(wy_reg) - OW'(xz_reg);
            zx_reg   <= OW'(z2_reg) + OW'(x2_reg);
            yx_reg   <= OW'(y2_reg) + OW'(x2_reg);
            w2p_reg  <= w1_reg;
            y2p_reg  <= y1_reg;
        end
    end

    // stage 3: singularity test and operand selection
    logic signed [CW-1:0] lhs, edge_lim;
    qte_pkg::sing_case_t  kase;
    logic signed [OW-1:0] zy_op, zx_op, yy_op, yx_op;
    logic [OW-1:0]        abcd_abs;

    always_comb begin
        lhs      = CW'(abcd_reg) <<< 23;
        edge_lim = (CW'(unit_reg) <<< 22) - CW'(unit_reg);
        if (lhs > edge_lim) begin
            kase = qte_pkg::CASE_POS;
        end else if (lhs < -edge_lim) begin
            kase = qte_pkg::CASE_NEG;
        end else begin
            kase = qte_pkg::CASE_REGULAR;
        end
        if (kase != qte_pkg::CASE_REGULAR) begin
            zy_op = OW'(y2p_reg);
            zx_op = OW'(w2p_reg);
        end else begin
            zy_op = adbc_reg <<< 1;
            zx_op = (OW'(1) <<< 28) - (zx_reg <<< 1);
        end
        yy_op    = acbd_reg <<< 1;
        yx_op    = (OW'(1) <<< 28) - (yx_reg <<< 1);
        abcd_abs = abcd_reg[OW-1] ? -abcd_reg : abcd_reg;
    end

    logic signed [OW-1:0]          zy3_reg, zx3_reg, yy3_reg, yx3_reg;
    logic [qte_pkg::DIV_W-1:0]     mag3_reg, unit3_reg;
    logic                          neg3_reg, zero3_reg;
    qte_pkg::sing_case_t           case_dly_reg [0:CL];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            zy3_reg         <= zy_op;
            zx3_reg         <= zx_op;
            yy3_reg         <= yy_op;
            yx3_reg         <= yx_op;
            mag3_reg        <= qte_pkg::DIV_W'(abcd_abs << 1);
            unit3_reg       <= qte_pkg::DIV_W'(unit_reg);
            neg3_reg        <= abcd_reg[OW-1];
            zero3_reg       <= (unit_reg == '0);
        end
    end

    // early angles about z and y
    logic signed [AW-1:0] ang_z, ang_y, ang_x;

    qte_atan2 u_atan_z (
        .aclk  (aclk),
        .en    (pipe_en),
        .in_y  (zy3_reg),
        .in_x  (zx3_reg),
        .angle (ang_z)
    );

    qte_atan2 u_atan_y (
        .aclk  (aclk),
        .en    (pipe_en),
        .in_y  (yy3_reg),
        .in_x  (yx3_reg),
        .angle (ang_y)
    );

    // asin path
    logic signed [qte_pkg::R_W-1:0] ratio;
    logic [qte_pkg::Q_W-1:0]        cosine;

    qte_ratio u_ratio (
        .aclk      (aclk),
        .en        (pipe_en),
        .num_mag   (mag3_reg),
        .unit      (unit3_reg),
        .num_neg   (neg3_reg),
        .unit_zero (zero3_reg),
        .ratio     (ratio),
        .cosine    (cosine)
    );

    qte_atan2 u_atan_x (
        .aclk  (aclk),
        .en    (pipe_en),
        .in_y  (OW'(ratio)),
        .in_x  (OW'(cosine)),
        .angle (ang_x)
    );

    // delay lines
    qte_pkg::early_ang_t early_dly_reg [0:RL-1];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            early_dly_reg[0] <= '{z: ang_z, y: ang_y};
            for (int i = 1; i < RL; i++) begin
                early_dly_reg[i] <= early_dly_reg[i-1];
            end
            case_dly_reg[0] <= kase;
            for (int i = 1; i <= CL; i++) begin
                case_dly_reg[i] <= case_dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PL; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (pipe_en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < PL; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // output combine
    qte_pkg::sing_case_t  out_case;
    qte_pkg::early_ang_t  out_early;
    logic signed [AW-1:0] az_next;
    logic signed [15:0]   ax_next, ay_next;

    always_comb begin
        out_case  = case_dly_reg[CL];
        out_early = early_dly_reg[RL-1];
        case (out_case)
            qte_pkg::CASE_POS: begin
                az_next = out_early.z <<< 1;
                ax_next = 16'(qte_pkg::PI_Q13);
                ay_next = '0;
            end
            qte_pkg::CASE_NEG: begin
                az_next = -(out_early.z <<< 1);
                ax_next = -16'(qte_pkg::PI_Q13);
                ay_next = '0;
            end
            default: begin
                az_next = out_early.z;
                ax_next = ang_x[15:0];
                ay_next = out_early.y[15:0];
            end
        endcase
    end

    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        out_hold;

    assign out_hold = m_tvalid_reg && !m_tready;
    assign pipe_en  = !(out_hold && vld_reg[PL-1]);
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!out_hold) begin
            m_tvalid_reg <= vld_reg[PL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_hold) begin
            m_tdata_reg <= {7'b0, ay_next, ax_next, az_next};
            m_tuser_reg <= out_case;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid_reg && !m_tready && vld_reg[PL-1]))
        else $error("input stalled without a blocked result");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted request lost at pipeline entry");

    a_sing_y_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tuser_reg == qte_pkg::CASE_POS || m_tuser_reg == qte_pkg::CASE_NEG))
        |-> (m_tdata_reg[48:33] == 16'd0))
        else $error("singular result with nonzero y angle");

    a_pos_pi: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == qte_pkg::CASE_POS)
        |-> (m_tdata_reg[32:17] == 16'(qte_pkg::PI_Q13)))
        else $error("positive singularity without x angle of pi");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for quaternion_to_euler_core: directed table plus random quaternions.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = qte_pkg::PIPE_LAT + 20;
    localparam int RANDOM_ITEMS   = 400;

    typedef struct packed {
        logic signed [16:0]  az;
        logic signed [15:0]  ax;
        logic signed [15:0]  ay;
        qte_pkg::sing_case_t kase;
    } euler_t;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        bit                 typed;  // expected angles given in the row
        euler_t             angles;
    } quat_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    quaternion_to_euler_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #2 aclk = ~aclk;

    euler_t     pending_angles[$];
    quat_row_t  stim[$];
    int         errors = 0;
    int         idle_cycles = 0;
    bit         hold_sink = 1'b0;
    bit         stim_done = 1'b0;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint atan2_q13(longint y, longint x);
        longint acc, t, dx, dy;
        longint tab[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
        acc = 0;
        if (x == 0 && y == 0) return 0;
        while (abs64(x) < (64'sd1 << 40) && abs64(y) < (64'sd1 << 40)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; acc = qte_pkg::HALF_PI_Q16;
            end else begin
                t = x; x = -y; y = t; acc = -qte_pkg::HALF_PI_Q16;
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; acc += tab[i];
            end else begin
                x -= dx; y += dy; acc -= tab[i];
            end
        end
        return floor_shr(acc + 4, 3);
    endfunction

    function automatic longint isqrt_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic euler_t quat_to_euler(longint w, longint x, longint y, longint z);
        euler_t e;
        longint unit_len, wxyz, lhs, margin, r, q, c;
        longint one;
        one = 64'sd1 << 28;
        unit_len = w*w + x*x + y*y + z*z;
        wxyz = w*x + y*z;
        lhs = wxyz * (64'sd1 << 23);
        margin = unit_len * (64'sd1 << 22) - unit_len;
        if (lhs > margin) begin
            e.az = 17'(2 * atan2_q13(y, w));
            e.ax = 16'(qte_pkg::PI_Q13);
            e.ay = '0;
            e.kase = qte_pkg::CASE_POS;
        end else if (lhs < -margin) begin
            e.az = 17'(-2 * atan2_q13(y, w));
            e.ax = 16'(-qte_pkg::PI_Q13);
            e.ay = '0;
            e.kase = qte_pkg::CASE_NEG;
        end else begin
            e.az = 17'(atan2_q13(2*(w*z - x*y), one - 2*(z*z + x*x)));
            e.ay = 16'(atan2_q13(2*(w*y - x*z), one - 2*(y*y + x*x)));
            r = 0;
            if (unit_len > 0) begin
                q = (abs64(2*wxyz) << 30) / unit_len;
                if (q > (64'sd1 << 30)) q = 64'sd1 << 30;
                r = wxyz < 0 ? -q : q;
            end
            c = isqrt_floor(longint'(64'd1 << 60) - r*r);
            e.ax = 16'(atan2_q13(r, c));
            e.kase = qte_pkg::CASE_REGULAR;
        end
        return e;
    endfunction

    function automatic euler_t angles(int az, int ax, int ay, qte_pkg::sing_case_t k);
        euler_t e;
        e.az = 17'(az);
        e.ax = 16'(ax);
        e.ay = 16'(ay);
        e.kase = k;
        return e;
    endfunction

    task automatic add_row(int w, int x, int y, int z, bit typed, euler_t e);
        quat_row_t r;
        r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
        r.typed = typed;
        r.angles = e;
        stim.push_back(r);
    endtask

    function automatic int rand_comp();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16384 : -16384;
            1:       return int'($urandom_range(0, 65535)) - 32768;  // full field
            2:       return int'($urandom_range(0, 64)) - 32;
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    // near a gimbal singularity: w ~ x and y ~ z (or mirrored), with a small nudge
    task automatic add_near_singular();
        int a, b, s;
        a = int'($urandom_range(0, 11585));
        b = int'($urandom_range(0, 11585));
        s = $urandom_range(0, 1) ? 1 : -1;
        add_row(a, s*a + int'($urandom_range(0, 6)) - 3,
                b, s*b + int'($urandom_range(0, 6)) - 3, 1'b0, '0);
    endtask

    // directed table
    initial begin
        euler_t z;
        z = '0;
        add_row(0, 0, 0, 0, 1'b1, angles(0, 0, 0, qte_pkg::CASE_REGULAR));
        add_row(16384, 0, 0, 0, 1'b1, angles(0, 0, 0, qte_pkg::CASE_REGULAR));
        add_row(16384, 16384, 0, 0, 1'b1, angles(0, 25736, 0, qte_pkg::CASE_POS));
        add_row(16384, -16384, 0, 0, 1'b1, angles(0, -25736, 0, qte_pkg::CASE_NEG));
        add_row(8192, 8192, 8192, 8192, 1'b0, z);
        add_row(8192, -8192, -8192, 8192, 1'b0, z);
        add_row(-16384, 0, 0, 0, 1'b0, z);
        add_row(0, 16384, 0, 0, 1'b0, z);
        add_row(0, 0, 16384, 0, 1'b0, z);
        add_row(0, 0, 0, 16384, 1'b0, z);
        add_row(0, 0, -16384, 0, 1'b0, z);
        add_row(-32768, -32768, -32768, -32768, 1'b0, z);
        add_row(32767, 32767, 32767, 32767, 1'b0, z);
        add_row(-32768, 32767, 0, 0, 1'b0, z);
        add_row(-8192, -8192, 8192, 8192, 1'b0, z);
        add_row(-8192, -8192, -8192, 8192, 1'b0, z);
        add_row(1, 0, 0, 0, 1'b0, z);
        add_row(0, 0, 0, -1, 1'b0, z);
        add_row(11585, 11585, 0, 0, 1'b0, z);
        add_row(11585, 11584, 0, 0, 1'b0, z);
        add_row(-16384, 0, -1, 0, 1'b0, z);
        add_row(-16384, 0, 1, 0, 1'b0, z);
        add_row(0, -16384, 0, -16384, 1'b0, z);
        add_row(12000, -7000, 3000, -5000, 1'b0, z);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 4) == 0) add_near_singular();
            else add_row(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 1'b0, z);
        end
    end

    // sender
    initial begin
        quat_row_t r;
        euler_t    e;
        int        gap;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < stim.size(); i++) begin
            r = stim[i];
            if (i == 60) begin
                // pause until the pipe has drained completely
                s_tvalid <= 1'b0;
                while (pending_angles.size() != 0) @(posedge aclk);
            end
            gap = 0;
            if ($urandom_range(0, 3) == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
            end
            if (i >= 100 && i < 250) gap = 0;  // back to back while the sink stalls
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {r.z, r.y, r.x, r.w};
            e = quat_to_euler(r.w, r.x, r.y, r.z);
            if (r.typed && e != r.angles) begin
                $display("%0t table row %0d: expected %p, predictor %p", $time, i, r.angles, e);
                errors++;
            end
            pending_angles.push_back(r.typed ? r.angles : e);
            do @(posedge aclk); while (!s_tready);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                    : $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // long receiver hold-off so the pipe fills and backpressures the input
    initial begin
        @(posedge aresetn);
        repeat (400) @(posedge aclk);
        hold_sink = 1'b1;
        repeat (300) @(posedge aclk);
        hold_sink = 1'b0;
    end

    // result checker
    always @(posedge aclk) begin
        euler_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.az = m_tdata[16:0];
            got.ax = m_tdata[32:17];
            got.ay = m_tdata[48:33];
            got.kase = qte_pkg::sing_case_t'(m_tuser);
            if (pending_angles.size() == 0) begin
                $display("%0t unexpected result: actual %p", $time, got);
                errors++;
            end else begin
                want = pending_angles.pop_front();
                if (got.az !== want.az || got.ax !== want.ax || got.ay !== want.ay
                    || got.kase !== want.kase || m_tdata[55:49] !== '0) begin
                    $display("%0t mismatch: expected %p, actual %p pad=%h",
                             $time, want, got, m_tdata[55:49]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("quaternion_to_euler_core regression: fail");
            $finish;
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        while (pending_angles.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_angles.size() == 0) begin
            $display("quaternion_to_euler_core regression: pass");
        end else begin
            $display("quaternion_to_euler_core regression: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/qte_pkg.sv
rtl/core/qte_atan2.sv
rtl/core/qte_ratio.sv
rtl/core/quaternion_to_euler_core.sv
test/testbench.sv
